### src/tdl_pkg.sv
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types and constants of the touch dimmer lamp controller.
// ----------------------------------------------------------------------------
package tdl_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// operation codes
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_WORK_START = 2'd1;
	localparam logic [1:0] OP_WORK_END   = 2'd2;

	// register indexes (byte address 4*index)
	localparam logic [1:0] REG_MAX_LUX    = 2'd0;
	localparam logic [1:0] REG_STEP_GAP   = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE   = 2'd2;
	localparam logic [1:0] REG_LONG_PRESS = 2'd3;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd5;
	localparam logic [15:0] LONG_PRESS_RST = 16'd2000;

	typedef struct packed {
		logic [15:0] max_lux;
		logic [7:0]  step_gap_ticks;
		logic [15:0] debounce_ticks;
		logic [15:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pwm_width;
		logic [15:0] brightness_target;
		logic        shut_down;
		logic        dimming;
		logic        work_hours;
	} res_t;

endpackage

### src/tdl_cfg.sv
// ----------------------------------------------------------------------------
// tdl_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module tdl_cfg
	import tdl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output cfg_t                cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_lux          <= 16'd0;
			cfg_q.step_gap_ticks   <= 8'd0;
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_LUX:    cfg_q.max_lux          <= pwdata[15:0];
				REG_STEP_GAP:   cfg_q.step_gap_ticks   <= pwdata[7:0];
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= pwdata[15:0];
				REG_LONG_PRESS: cfg_q.long_press_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_LUX:    prdata = {16'd0, cfg_q.max_lux};
			REG_STEP_GAP:   prdata = {24'd0, cfg_q.step_gap_ticks};
			REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_ticks};
			REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_ticks};
			default:        prdata = '0;
		endcase
	end

endmodule

### src/tdl_core.sv
// ----------------------------------------------------------------------------
// tdl_core
// Lamp state and its one-event update: touch timing, dimming ramp, targets.
// ----------------------------------------------------------------------------
module tdl_core
	import tdl_pkg::*;
#(
	parameter logic [15:0] PWM_FULL_W = 16'd1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] op,
	input  logic       touch,
	input  logic       motion,
	input  cfg_t       cfg,
	output res_t       res
);

	logic [31:0] tick_q, tick_n;
	logic [15:0] press_q, press_n;
	logic [31:0] last_q, last_n;
	logic [15:0] width_q, width_n;
	logic [15:0] goal_q, goal_n;
	logic [15:0] light_q, light_n;
	logic        sd_q, sd_n;
	logic        dim_q, dim_n;
	logic        wh_q, wh_n;

	always_comb begin
		tick_n  = tick_q;
		press_n = press_q;
		last_n  = last_q;
		width_n = width_q;
		goal_n  = goal_q;
		light_n = light_q;
		sd_n    = sd_q;
		dim_n   = dim_q;
		wh_n    = wh_q;
		case (op)
			OP_TICK: begin
				tick_n = tick_q + 32'd1;
				if (!sd_q && wh_q && !dim_q) begin
					light_n = motion ? {1'b0, cfg.max_lux[15:1]} : cfg.max_lux;
				end
				if (touch) begin
					// press counter saturates
					if (press_q != 16'hFFFF) begin
						press_n = press_q + 16'd1;
					end
				end else begin
					if (press_q > cfg.long_press_ticks) begin
						width_n = PWM_FULL_W;
						light_n = 16'd0;
						sd_n    = 1'b1;
						goal_n  = 16'd0;
						dim_n   = 1'b1;
					end else if (press_q > cfg.debounce_ticks) begin
						dim_n = 1'b1;
						if (width_q == 16'd0) begin
							goal_n  = PWM_FULL_W;
							sd_n    = 1'b0;
							light_n = cfg.max_lux;
						end else begin
							goal_n  = 16'd0;
							light_n = 16'd0;
						end
					end
					press_n = 16'd0;
				end
				if (dim_n) begin
					// gap measured modulo 2^32
					if ((tick_n - last_q) > {24'd0, cfg.step_gap_ticks}) begin
						last_n = tick_n;
						if (width_n > goal_n) begin
							width_n = width_n - 16'd1;
						end else if (width_n < goal_n) begin
							width_n = width_n + 16'd1;
						end
					end
					if (goal_n == width_n) begin
						dim_n = 1'b0;
					end
				end
			end
			OP_WORK_START: begin
				light_n = cfg.max_lux;
				goal_n  = PWM_FULL_W;
				dim_n   = 1'b1;
				wh_n    = 1'b1;
				sd_n    = 1'b0;
			end
			OP_WORK_END: begin
				light_n = 16'd0;
				goal_n  = 16'd0;
				dim_n   = 1'b1;
				wh_n    = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			press_q <= '0;
			last_q  <= '0;
			width_q <= '0;
			goal_q  <= '0;
			light_q <= '0;
			sd_q    <= 1'b0;
			dim_q   <= 1'b0;
			wh_q    <= 1'b0;
		end else if (fire) begin
			tick_q  <= tick_n;
			press_q <= press_n;
			last_q  <= last_n;
			width_q <= width_n;
			goal_q  <= goal_n;
			light_q <= light_n;
			sd_q    <= sd_n;
			dim_q   <= dim_n;
			wh_q    <= wh_n;
		end
	end

	assign res.pwm_width         = width_n;
	assign res.brightness_target = light_n;
	assign res.shut_down         = sd_n;
	assign res.dimming           = dim_n;
	assign res.work_hours        = wh_n;

	a_shutdown_dark: assert property (@(posedge clk) disable iff (!arst_n)
		sd_q |-> light_q == 16'd0)
		else $error("shut down lamp has nonzero brightness target");

	a_work_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_WORK_START |=> wh_q && dim_q && !sd_q)
		else $error("work start did not open work hours and start dimming");

	a_press_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_TICK && touch |=> press_q != 16'd0)
		else $error("press counter zero after pressed tick");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(width_q) && $stable(tick_q) && $stable(press_q))
		else $error("lamp state changed without an event");

endmodule

### src/touch_dimmer_lamp_controller.sv
// an accepted request goes through the input register, then the result register (out_valid)
// throughput: one request per cycle while in_stall is low, the lamp state updates in a single pass
// out_stall propagates to in_stall only while both stages hold a request
// reset: arst_n clears lamp state, config and valid flags, not the data registers; debounce 5, long press 2000
// ----------------------------------------------------------------------------
// touch_dimmer_lamp_controller
// Top level: input stage, lamp state update, result register, config port.
// ----------------------------------------------------------------------------
module touch_dimmer_lamp_controller
	import tdl_pkg::*;
#(
	parameter int unsigned PWM_FULL = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic              touch_level,
	input  logic              motion_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       pwm_width,
	output logic [15:0]       brightness_target,
	output logic              shut_down,
	output logic              dimming,
	output logic              work_hours
);

	localparam logic [15:0] PWM_FULL_W = PWM_FULL[15:0];

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1, valid_s2;
	logic [1:0] op_s1;
	logic       touch_s1, motion_s1;
	logic       fire;

	tdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request moves from the input stage into the result register
	assign fire     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1     <= operation;
			touch_s1  <= touch_level;
			motion_s1 <= motion_level;
		end
	end

	tdl_core #(
		.PWM_FULL_W (PWM_FULL_W)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.touch  (touch_s1),
		.motion (motion_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign pwm_width         = res_s2.pwm_width;
	assign brightness_target = res_s2.brightness_target;
	assign shut_down         = res_s2.shut_down;
	assign dimming           = res_s2.dimming;
	assign work_hours        = res_s2.work_hours;

endmodule

### verif/touch_dimmer_lamp_controller_test.sv
// ----------------------------------------------------------------------------
// touch_dimmer_lamp_controller_test
// Self-checking bench for the lamp controller. A queue-fed driver sends tick,
// work start/end and unused-op requests, a monitor checks every result field
// against an in-bench lamp predictor; registers are rewritten between phases.
// ----------------------------------------------------------------------------
module touch_dimmer_lamp_controller_test;
	import tdl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  OP_UNUSED = 2'd3;
	localparam logic [15:0] PWM_FULL  = 16'd1023;
	localparam int          HOLD_LEN  = 100;

	typedef struct packed {
		logic [1:0] op;
		logic       touch;
		logic       motion;
	} lamp_req_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        operation    = OP_TICK;
	logic              touch_level  = 1'b0;
	logic              motion_level = 1'b0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [15:0]       pwm_width;
	logic [15:0]       brightness_target;
	logic              shut_down;
	logic              dimming;
	logic              work_hours;

	touch_dimmer_lamp_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.touch_level(touch_level),
		.motion_level(motion_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_width(pwm_width),
		.brightness_target(brightness_target),
		.shut_down(shut_down),
		.dimming(dimming),
		.work_hours(work_hours)
	);

	always #1 clk = ~clk;

	// lamp predictor state and register copy
	cfg_t        lamp_cfg = '{max_lux: 16'd0, step_gap_ticks: 8'd0,
		debounce_ticks: DEBOUNCE_RST, long_press_ticks: LONG_PRESS_RST};
	logic [31:0] ticks_seen   = '0;
	logic [15:0] press_ticks  = '0;
	logic [31:0] last_step_at = '0;
	logic [15:0] width_cur    = '0;
	logic [15:0] width_target = '0;
	logic [15:0] light_target = '0;
	logic        lamp_shut    = 1'b0;
	logic        lamp_dimming = 1'b0;
	logic        lamp_work    = 1'b0;

	lamp_req_t lamp_requests[$];
	res_t      lamp_expect[$];
	lamp_req_t next_req;
	int        mismatches = 0;
	bit        quiet      = 1'b0;
	int        hold_asked = 0;
	int        hold_seen  = 0;
	int        hold_left  = 0;

	function automatic res_t lamp_step(input logic [1:0] op, input logic touch,
		input logic motion);
		res_t r;
		if (op == OP_TICK) begin
			ticks_seen = ticks_seen + 32'd1;
			if (!lamp_shut && lamp_work && !lamp_dimming)
				light_target = motion ? (lamp_cfg.max_lux >> 1) : lamp_cfg.max_lux;
			if (touch) begin
				if (press_ticks != 16'hFFFF)
					press_ticks = press_ticks + 16'd1;
			end else begin
				if (press_ticks > lamp_cfg.long_press_ticks) begin
					width_cur    = PWM_FULL;
					light_target = '0;
					lamp_shut    = 1'b1;
					width_target = '0;
					lamp_dimming = 1'b1;
				end else if (press_ticks > lamp_cfg.debounce_ticks) begin
					width_target = (width_cur != 0) ? 16'd0 : PWM_FULL;
					lamp_dimming = 1'b1;
					if (width_target != 0) begin
						lamp_shut    = 1'b0;
						light_target = lamp_cfg.max_lux;
					end else begin
						light_target = '0;
					end
				end
				press_ticks = '0;
			end
			if (lamp_dimming) begin
				if ((ticks_seen - last_step_at) > {24'd0, lamp_cfg.step_gap_ticks}) begin
					last_step_at = ticks_seen;
					if (width_cur > width_target)
						width_cur = width_cur - 16'd1;
					else if (width_cur < width_target)
						width_cur = width_cur + 16'd1;
				end
				if (width_target == width_cur)
					lamp_dimming = 1'b0;
			end
		end else if (op == OP_WORK_START) begin
			light_target = lamp_cfg.max_lux;
			width_target = PWM_FULL;
			lamp_dimming = 1'b1;
			lamp_work    = 1'b1;
			lamp_shut    = 1'b0;
		end else if (op == OP_WORK_END) begin
			light_target = '0;
			width_target = '0;
			lamp_dimming = 1'b1;
			lamp_work    = 1'b0;
		end
		r.pwm_width         = width_cur;
		r.brightness_target = light_target;
		r.shut_down         = lamp_shut;
		r.dimming           = lamp_dimming;
		r.work_hours        = lamp_work;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// driver: new request loads once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			operation    <= OP_TICK;
			touch_level  <= 1'b0;
			motion_level <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				lamp_expect.push_back(lamp_step(operation, touch_level, motion_level));
			if (!in_valid || !in_stall) begin
				if (lamp_requests.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
					next_req = lamp_requests.pop_front();
					in_valid     <= 1'b1;
					operation    <= next_req.op;
					touch_level  <= next_req.touch;
					motion_level <= next_req.motion;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall, with a long hold-off whenever one is asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 8);
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (lamp_expect.size() == 0) begin
				report_mismatch("unexpected result", pwm_width, 0);
			end else begin
				want = lamp_expect.pop_front();
				if (pwm_width !== want.pwm_width)
					report_mismatch("pwm_width", pwm_width, want.pwm_width);
				if (brightness_target !== want.brightness_target)
					report_mismatch("brightness_target", brightness_target,
						want.brightness_target);
				if (shut_down !== want.shut_down)
					report_mismatch("shut_down", shut_down, want.shut_down);
				if (dimming !== want.dimming)
					report_mismatch("dimming", dimming, want.dimming);
				if (work_hours !== want.work_hours)
					report_mismatch("work_hours", work_hours, want.work_hours);
			end
		end
	end

	task automatic push_req(input logic [1:0] op, input logic touch, input logic motion);
		lamp_requests.push_back('{op: op, touch: touch, motion: motion});
	endtask

	task automatic push_press(input int len);
		repeat (len) push_req(OP_TICK, 1'b1, 1'($urandom_range(1)));
		push_req(OP_TICK, 1'b0, 1'($urandom_range(1)));
	endtask

	// mostly well-formed presses and tick runs, some work start/end and noise
	task automatic push_random(input int n);
		int made;
		int pick;
		int len;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				len = $urandom_range(int'(lamp_cfg.long_press_ticks) + 3);
				push_press(len);
				made += len + 1;
			end else if (pick < 75) begin
				len = $urandom_range(1, 12);
				repeat (len) push_req(OP_TICK, 1'b0, 1'($urandom_range(1)));
				made += len;
			end else if (pick < 83) begin
				push_req(OP_WORK_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
				made++;
			end else if (pick < 90) begin
				push_req(OP_WORK_END, 1'($urandom_range(1)), 1'($urandom_range(1)));
				made++;
			end else if (pick < 95) begin
				push_req(OP_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				push_req(2'($urandom_range(2)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				made++;
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (lamp_requests.size() != 0 || in_valid || lamp_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MAX_LUX:    lamp_cfg.max_lux          = val;
			REG_STEP_GAP:   lamp_cfg.step_gap_ticks   = val[7:0];
			REG_DEBOUNCE:   lamp_cfg.debounce_ticks   = val;
			REG_LONG_PRESS: lamp_cfg.long_press_ticks = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings
		push_req(OP_WORK_START, 1'b0, 1'b0);
		push_req(OP_TICK, 1'b1, 1'b1);
		push_req(OP_WORK_END, 1'b0, 1'b0);
		wait_idle();

		reg_write(REG_MAX_LUX, 16'hFFFF);
		reg_write(REG_STEP_GAP, 16'd0);
		reg_write(REG_DEBOUNCE, 16'd2);
		reg_write(REG_LONG_PRESS, 16'd6);
		push_req(OP_UNUSED, 1'b1, 1'b1);
		push_req(OP_UNUSED, 1'b0, 1'b0);
		push_req(OP_WORK_START, 1'b0, 1'b0);
		// short toggle while ramping up, then ramp back to zero
		push_req(OP_TICK, 1'b1, 1'b0);
		push_req(OP_TICK, 1'b1, 1'b1);
		push_req(OP_TICK, 1'b1, 1'b0);
		push_req(OP_TICK, 1'b0, 1'b1);
		repeat (3) push_req(OP_TICK, 1'b0, 1'b0);
		// settled in work hours: motion halves the target
		push_req(OP_TICK, 1'b0, 1'b1);
		push_req(OP_TICK, 1'b0, 1'b0);
		repeat (7) push_req(OP_TICK, 1'b1, 1'b0);
		push_req(OP_TICK, 1'b0, 1'b0);
		push_req(OP_TICK, 1'b0, 1'b1);
		push_req(OP_WORK_END, 1'b1, 1'b1);
		push_req(OP_WORK_START, 1'b1, 1'b0);
		wait_idle();

		push_random(250);
		hold_asked++;
		wait_idle();

		reg_write(REG_MAX_LUX, 16'($urandom_range(65535)));
		reg_write(REG_STEP_GAP, 16'd255);
		reg_write(REG_DEBOUNCE, 16'd0);
		reg_write(REG_LONG_PRESS, 16'd0);
		quiet = 1'b1;
		push_random(150);
		wait_idle();
		quiet = 1'b0;

		reg_write(REG_MAX_LUX, 16'd0);
		reg_write(REG_STEP_GAP, 16'd3);
		reg_write(REG_DEBOUNCE, 16'd4);
		reg_write(REG_LONG_PRESS, 16'd12);
		push_random(300);
		hold_asked++;
		wait_idle();

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
src/tdl_pkg.sv
src/tdl_cfg.sv
src/tdl_core.sv
src/touch_dimmer_lamp_controller.sv
verif/touch_dimmer_lamp_controller_test.sv
